>>> sv/cmc_pkg.sv
// Shared types and constants for the circular arc maximum-overlap block.
// Depends on nothing; every other file imports it.
package cmc_pkg;
  localparam int MAX_ARCS   = 64;
  localparam int ANGLE_BITS = 16;
  localparam int DEPTH      = 4 * MAX_ARCS;
  localparam int EA_W       = ANGLE_BITS + 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int ARC_W      = $clog2(MAX_ARCS + 1);
  localparam int RUN_W      = $clog2(MAX_ARCS) + 3;

  localparam logic signed [EA_W-1:0] HALF_TURN = EA_W'(1) <<< (ANGLE_BITS - 1);

  typedef struct packed {
    logic                   valid;
    logic                   up;
    logic signed [EA_W-1:0] angle;
  } ev_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS,
    S_SWEEP,
    S_DONE
  } state_t;
endpackage

>>> sv/cmc_cell.sv
// One cell of the sorted event chain: holds one event, inserts or shifts.
// Depends on cmc_pkg.
module cmc_cell (
  input  logic          clk,
  input  logic          rst,
  input  cmc_pkg::ctl_t ctl,
  input  cmc_pkg::ev_t  new_ev,
  input  cmc_pkg::ev_t  prev_ev,
  input  logic          prev_gt,
  input  cmc_pkg::ev_t  next_ev,
  output cmc_pkg::ev_t  ev,
  output logic          gt
);
  import cmc_pkg::*;

  // empty cells count as greater than anything
  assign gt = !ev.valid || (ev.angle > new_ev.angle);

  always_ff @(posedge clk) begin
    if (rst) begin
      ev.valid <= 1'b0;
    end else if (ctl.shift) begin
      ev <= next_ev;
    end else if (ctl.insert && gt) begin
      ev <= prev_gt ? prev_ev : new_ev;
    end
  end
endmodule

>>> sv/cmc_sweep.sv
// Sweep unit: running overlap and best segment over events popped in order.
// Depends on cmc_pkg.
module cmc_sweep (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               clr,
  input  logic                               en,
  input  cmc_pkg::ev_t                       head,
  input  cmc_pkg::ev_t                       nxt,
  output logic signed [cmc_pkg::ANGLE_BITS-1:0] heading
);
  import cmc_pkg::*;

  logic signed [RUN_W-1:0] running, best, run_n;
  logic signed [EA_W-1:0]  best_start, best_end, seg_end;
  logic signed [EA_W:0]    len, best_len, sum;
  logic                    take;

  always_comb begin
    run_n    = head.up ? running + RUN_W'(1) : running - RUN_W'(1);
    seg_end  = nxt.valid ? nxt.angle : HALF_TURN;
    len      = (EA_W+1)'(seg_end) - (EA_W+1)'(head.angle);
    best_len = (EA_W+1)'(best_end) - (EA_W+1)'(best_start);
    take     = (seg_end > head.angle) &&
               ((run_n > best) || (run_n == best && run_n > 0 && len > best_len));
    sum      = (EA_W+1)'(best_start) + (EA_W+1)'(best_end);
    heading  = (best > 0) ? ANGLE_BITS'(sum >>> 1) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      running    <= '0;
      best       <= '0;
      best_start <= -HALF_TURN;
      best_end   <= HALF_TURN;
    end else if (en) begin
      running <= run_n;
      if (take) begin
        best       <= run_n;
        best_start <= head.angle;
        best_end   <= seg_end;
      end
    end
  end
endmodule

>>> sv/circular_arc_max_overlap.sv
// Circular arc maximum overlap: sorted insertion chain plus an in-order sweep.
// An arc word is accepted in S_IDLE; its 2 or 4 events (4 for a wrapping arc) then go
// into the cell chain one event per cycle in S_INS. After the last word the sweep pops
// every event held and S_DONE registers the heading. No new word is taken outside S_IDLE.
// Reset (rst, synchronous): empties the chain and clears the sweep registers.
// Depends on cmc_pkg, cmc_cell and cmc_sweep.
module circular_arc_max_overlap (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [cmc_pkg::ANGLE_BITS-1:0] arc_start,
  input  logic signed [cmc_pkg::ANGLE_BITS-1:0] arc_end,
  input  logic                                 arc_valid,
  input  logic                                 last,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [cmc_pkg::ANGLE_BITS-1:0] heading
);
  import cmc_pkg::*;

  state_t state, state_next;
  ev_t    ev_buf [4];
  logic [2:0]       ev_n;
  logic [1:0]       idx;
  logic             last_q;
  logic [ARC_W-1:0] arcs_held;
  logic [CNT_W-1:0] event_total;

  ev_t  cell_ev [DEPTH];
  logic cell_gt [DEPTH];
  ctl_t ctl;
  ev_t  new_ev;
  logic accept, take_arc, load_out, sweep_en;
  logic signed [EA_W-1:0] s_ext, e_ext;
  logic signed [ANGLE_BITS-1:0] sw_heading;

  assign accept   = in_valid && !in_stall;
  assign s_ext    = EA_W'(arc_start);
  assign e_ext    = EA_W'(arc_end);
  assign take_arc = arc_valid && (arcs_held < ARC_W'(MAX_ARCS));
  assign new_ev   = ev_buf[idx];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (take_arc) state_next = S_INS;
          else if (last) state_next = S_SWEEP;
        end
      end
      S_INS: begin
        if (3'(idx) == ev_n - 3'd1) state_next = last_q ? S_SWEEP : S_IDLE;
      end
      S_SWEEP: begin
        if (!cell_ev[0].valid) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall   = (state != S_IDLE);
    ctl.insert = (state == S_INS) && (event_total < CNT_W'(DEPTH));
    sweep_en   = (state == S_SWEEP) && cell_ev[0].valid;
    ctl.shift  = sweep_en;
    load_out   = (state == S_DONE) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      arcs_held   <= '0;
      event_total <= '0;
      idx         <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        idx    <= '0;
        last_q <= last;
        ev_n   <= (s_ext <= e_ext) ? 3'd2 : 3'd4;
        if (take_arc) arcs_held <= arcs_held + ARC_W'(1);
        // split a wrapping arc at plus and minus half a turn
        ev_buf[0] <= '{valid: 1'b1, up: 1'b1, angle: s_ext};
        if (s_ext <= e_ext) begin
          ev_buf[1] <= '{valid: 1'b1, up: 1'b0, angle: e_ext};
        end else begin
          ev_buf[1] <= '{valid: 1'b1, up: 1'b0, angle: HALF_TURN};
          ev_buf[2] <= '{valid: 1'b1, up: 1'b1, angle: -HALF_TURN};
          ev_buf[3] <= '{valid: 1'b1, up: 1'b0, angle: e_ext};
        end
      end else if (state == S_INS) begin
        idx <= idx + 2'd1;
      end
      if (ctl.insert) event_total <= event_total + CNT_W'(1);
      if (load_out) begin
        out_valid   <= 1'b1;
        arcs_held   <= '0;
        event_total <= '0;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) heading <= sw_heading;
  end

  // sorted chain: cell 0 holds the lowest angle; the sweep pops it each cycle while sweeping
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ev_t  p_ev, n_ev;
    logic p_gt;
    if (i == 0) begin : g_first
      assign p_ev = '0;
      assign p_gt = 1'b0;
    end else begin : g_mid
      assign p_ev = cell_ev[i-1];
      assign p_gt = cell_gt[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign n_ev = '0;
    end else begin : g_body
      assign n_ev = cell_ev[i+1];
    end
    cmc_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .new_ev (new_ev),
      .prev_ev(p_ev),
      .prev_gt(p_gt),
      .next_ev(n_ev),
      .ev     (cell_ev[i]),
      .gt     (cell_gt[i])
    );
  end

  cmc_sweep u_sweep (
    .clk    (clk),
    .rst    (rst),
    .clr    (load_out),
    .en     (sweep_en),
    .head   (cell_ev[0]),
    .nxt    (cell_ev[1]),
    .heading(sw_heading)
  );

  // occupied cells form a prefix of the chain, checked at its head
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    cell_ev[1].valid |-> cell_ev[0].valid)
    else $error("chain has a hole at its head");

  // a result only appears after the sweep finished
  a_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result without a finished sweep");

  // sorted order at the chain head
  a_sorted: assert property (@(posedge clk) disable iff (rst)
    cell_ev[1].valid |-> cell_ev[0].angle <= cell_ev[1].angle)
    else $error("chain head out of order");
endmodule
